// File: design/lags_pkg.sv
// ----------------------------------------------------------------------------
// lags_pkg
// Shared types and constants for the life automaton generation step: register
// indexes, command codes, the column triple that moves through the window and
// the B3/S23 rule.
// ----------------------------------------------------------------------------
package lags_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] GRID_WIDTH_RESET  = 10'd500;
    localparam logic [CFG_DATA_W-1:0] GRID_HEIGHT_RESET = 10'd500;

    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int COLUMN_W = 9;
    localparam int ROW_W    = 9;

    // one column of the 3x3 window: rows above, center and below
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } column_t;

    // live neighbour count, at most 8
    typedef logic [3:0] count_t;

    function automatic logic life_rule(input logic self, input count_t count);
        life_rule = (count == 4'd3) || (self && (count == 4'd2));
    endfunction

endpackage

// File: design/life_automaton_generation_step.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step
// One generation of the B3/S23 automaton over a raster stream of cells,
// with a per-column store of the two rows above and a 3x3 window.
// ----------------------------------------------------------------------------
// pipeline: an input transfer passes stage b, stage c and the output register
// throughput: one item per cycle unless out_ready stalls the output, set by
//   the single store read and write per item (write-back forwarded to the next)
// reset: counters and window cleared, grid size 500 x 500; the column store
//   is not cleared, out-of-grid neighbours are masked instead
module life_automaton_generation_step #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [lags_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lags_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic                               alive,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lags_pkg::COLUMN_W-1:0]      column,
    output logic [lags_pkg::ROW_W-1:0]         row,
    output logic                               next_alive,
    output logic                               last_of_frame
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int QRW = $clog2(MAX_HEIGHT);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int DWW = $clog2(MAX_WIDTH + 1);
    localparam int DHW = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [lags_pkg::CFG_DATA_W-1:0] grid_width_reg;
    logic [lags_pkg::CFG_DATA_W-1:0] grid_height_reg;
    logic [DWW-1:0]                  w;
    logic [DHW-1:0]                  h;

    // position counters
    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [RW-1:0]  in_row_reg,  in_row_next;
    logic [CW-1:0]  q_col_reg,   q_col_next;
    logic [QRW-1:0] q_row_reg,   q_row_next;

    // stage b: store read data arrives
    logic           b_valid_reg;
    logic           b_bit_reg;
    logic           b_emit_reg;
    logic           b_last_reg;
    logic [CW-1:0]  b_col_reg;
    logic [CW-1:0]  b_qc_reg;
    logic [QRW-1:0] b_qr_reg;
    logic           fwd_reg;
    logic [1:0]     fwd_data_reg;

    // stage c: window complete
    logic           c_valid_reg;
    logic           c_last_reg;
    logic [CW-1:0]  c_qc_reg;
    logic [QRW-1:0] c_qr_reg;
    lags_pkg::column_t win_left_reg, win_mid_reg, win_right_reg;

    // output register
    logic           out_valid_reg;
    logic [CW-1:0]  out_col_reg;
    logic [QRW-1:0] out_row_reg;
    logic           out_alive_reg;
    logic           out_last_reg;

    logic           en;
    logic           accept;
    logic           a_bit;
    logic           a_emit;
    logic           a_last;
    logic [1:0]     ram_rdata;
    logic [1:0]     col_word;
    logic [1:0]     wr_word;
    lags_pkg::column_t b_column;

    logic           left_ok, right_ok, top_ok, bot_ok;
    lags_pkg::count_t count;
    logic           c_next;

    // clamp register values into 1..max
    always_comb
    begin
        if (grid_width_reg == '0)
            w = DWW'(1);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            w = DWW'(MAX_WIDTH);
        else
            w = DWW'(grid_width_reg);

        if (grid_height_reg == '0)
            h = DHW'(1);
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
            h = DHW'(MAX_HEIGHT);
        else
            h = DHW'(grid_height_reg);
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    // input side: in-grid bit, whether a result is owed, end of frame
    assign a_bit  = (command == lags_pkg::CMD_CELL) && alive
                    && (32'(in_row_reg) < 32'(h));
    assign a_emit = (in_row_reg >= RW'(2))
                    || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign a_last = (32'(q_col_reg) + 32'd1 == 32'(w))
                    && (32'(q_row_reg) + 32'd1 == 32'(h));

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        q_col_next  = q_col_reg;
        q_row_next  = q_row_reg;
        if (cfg_we)
        begin
            in_col_next = '0;
            in_row_next = '0;
            q_col_next  = '0;
            q_row_next  = '0;
        end
        else if (accept)
        begin
            if (a_emit && a_last)
            begin
                in_col_next = '0;
                in_row_next = '0;
                q_col_next  = '0;
                q_row_next  = '0;
            end
            else
            begin
                if (32'(in_col_reg) + 32'd1 == 32'(w))
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
                if (a_emit)
                begin
                    if (32'(q_col_reg) + 32'd1 == 32'(w))
                    begin
                        q_col_next = '0;
                        q_row_next = q_row_reg + QRW'(1);
                    end
                    else
                    begin
                        q_col_next = q_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // word per column: [1] row just above, [0] two rows above
    lags_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_col_store (
        .clk   (clk),
        .we    (en && b_valid_reg),
        .waddr (b_col_reg),
        .wdata (wr_word),
        .re    (en),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    assign col_word       = fwd_reg ? fwd_data_reg : ram_rdata;
    assign wr_word        = {b_bit_reg, col_word[1]};
    assign b_column.top   = col_word[0];
    assign b_column.mid   = col_word[1];
    assign b_column.bot   = b_bit_reg;

    // neighbour masks around the center cell
    assign left_ok  = (c_qc_reg != '0);
    assign right_ok = (32'(c_qc_reg) + 32'd1 < 32'(w));
    assign top_ok   = (c_qr_reg != '0);
    assign bot_ok   = (32'(c_qr_reg) + 32'd1 < 32'(h));

    assign count = 4'(win_left_reg.top  && left_ok  && top_ok)
                 + 4'(win_left_reg.mid  && left_ok)
                 + 4'(win_left_reg.bot  && left_ok  && bot_ok)
                 + 4'(win_mid_reg.top   && top_ok)
                 + 4'(win_mid_reg.bot   && bot_ok)
                 + 4'(win_right_reg.top && right_ok && top_ok)
                 + 4'(win_right_reg.mid && right_ok)
                 + 4'(win_right_reg.bot && right_ok && bot_ok);

    assign c_next = lags_pkg::life_rule(win_mid_reg.mid, count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= lags_pkg::GRID_WIDTH_RESET;
            grid_height_reg <= lags_pkg::GRID_HEIGHT_RESET;
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            q_col_reg       <= '0;
            q_row_reg       <= '0;
            b_valid_reg     <= 1'b0;
            fwd_reg         <= 1'b0;
            c_valid_reg     <= 1'b0;
            win_left_reg    <= '0;
            win_mid_reg     <= '0;
            win_right_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lags_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    lags_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            q_col_reg  <= q_col_next;
            q_row_reg  <= q_row_next;

            if (en)
            begin
                b_valid_reg <= accept;
                // write-back of stage b to the column being read now
                fwd_reg     <= b_valid_reg && (b_col_reg == in_col_reg);
                c_valid_reg <= b_valid_reg && b_emit_reg;
                if (b_valid_reg)
                begin
                    win_left_reg  <= win_mid_reg;
                    win_mid_reg   <= win_right_reg;
                    win_right_reg <= b_column;
                end
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_bit_reg    <= a_bit;
            b_emit_reg   <= a_emit;
            b_last_reg   <= a_last;
            b_col_reg    <= in_col_reg;
            b_qc_reg     <= q_col_reg;
            b_qr_reg     <= q_row_reg;
            fwd_data_reg <= wr_word;
            c_last_reg   <= b_last_reg;
            c_qc_reg     <= b_qc_reg;
            c_qr_reg     <= b_qr_reg;
            out_col_reg   <= c_qc_reg;
            out_row_reg   <= c_qr_reg;
            out_alive_reg <= c_next;
            out_last_reg  <= c_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign column        = lags_pkg::COLUMN_W'(out_col_reg);
    assign row           = lags_pkg::ROW_W'(out_row_reg);
    assign next_alive    = out_alive_reg;
    assign last_of_frame = out_last_reg;

endmodule

// File: design/lags_ram.sv
// ----------------------------------------------------------------------------
// lags_ram
// Generic simple dual-port RAM, one write port and one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module lags_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
